// ===== design/stereo_fuzz_distortion_macros.svh =====
// ----------------------------------------------------------------------------
// Stereo fuzz distortion assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_FUZZ_DISTORTION_MACROS_SVH
`define STEREO_FUZZ_DISTORTION_MACROS_SVH

// Check cons in the same cycle as ante.
`define SFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo fuzz distortion package
// Beat types, configuration layout, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int SAMPLE_WIDTH     = 24;
    localparam int DRIVE_WIDTH      = 14;
    localparam int COEF_WIDTH       = 17;
    localparam int CFG_DATA_WIDTH   = 17;
    localparam int REG_INDEX_WIDTH  = 3;
    localparam int STATE_ADDR_WIDTH = 4;
    localparam int POLE_IDX_WIDTH   = 3;
    localparam int MUL_A_WIDTH      = 19;

    localparam logic [COEF_WIDTH-1:0] Q16_ONE = 17'd65536;

    localparam logic signed [MUL_A_WIDTH-1:0] K_LOWPASS_GAIN = 19'sd104858;
    localparam logic signed [MUL_A_WIDTH-1:0] K_DUCK         = 19'sd26214;
    localparam logic signed [MUL_A_WIDTH-1:0] K_MAKEUP       = 19'sd15729;

    localparam logic [REG_INDEX_WIDTH-1:0] REG_DRIVE_GAIN          = 3'd0;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_TONE_MIX            = 3'd1;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_CLEAN_BLEND         = 3'd2;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_INPUT_HIGHPASS = 3'd3;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_BASS_TAP       = 3'd4;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_INTERSTAGE     = 3'd5;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_TONE           = 3'd6;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_COEF_DC_BLOCK       = 3'd7;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_in;
        logic signed [SAMPLE_WIDTH-1:0] right_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
    } out_beat_t;

    typedef struct packed {
        logic [DRIVE_WIDTH-1:0] drive_gain;
        logic [COEF_WIDTH-1:0]  tone_mix;
        logic [COEF_WIDTH-1:0]  clean_blend;
        logic [COEF_WIDTH-1:0]  coef_input_highpass;
        logic [COEF_WIDTH-1:0]  coef_bass_tap;
        logic [COEF_WIDTH-1:0]  coef_interstage;
        logic [COEF_WIDTH-1:0]  coef_tone;
        logic [COEF_WIDTH-1:0]  coef_dc_block;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        drive_gain:          14'd10240,
        tone_mix:            17'd36045,
        clean_blend:         17'd29491,
        coef_input_highpass: 17'd385,
        coef_bass_tap:       17'd1526,
        coef_interstage:     17'd45360,
        coef_tone:           17'd5738,
        coef_dc_block:       17'd154
    };

    typedef struct packed {
        logic                        rd_en;
        logic                        wr_en;
        logic [STATE_ADDR_WIDTH-1:0] addr;
    } ram_ctrl_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } core_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_sts_t;

endpackage

// ===== design/stereo_fuzz_distortion.sv =====
// ----------------------------------------------------------------------------
// Stereo fuzz distortion
// Two-channel fuzz with tone crossfade, clean bass blend and DC blocker.
// ----------------------------------------------------------------------------
// Sample pairs enter on smp_valid/smp_ready with payload smp, processed pairs
// leave on res_valid/res_ready with payload res. Controls and filter
// coefficients are written through cfg_we/cfg_index/cfg_data, one register a
// cycle, while the block is idle; the user must keep to this, the block does
// not enforce it. One sequencer walks each channel through seven one-pole
// filters and eight multiplies, sharing one multiplier and one state memory
// port: a pole step reads its state, multiplies the coefficient by the
// difference and writes the new state; a multiply registers its product.
// A result beat shows once both channels of its pair are done, and smp_ready
// rises with it; no new pair is taken until the sequencer is idle again.
// The output register holds a finished pair while the next pair is worked
// on; if that pair finishes first, the sequencer holds its last step until
// the output register is taken.
// Reset zeroes all filter states, loads the default controls and empties
// the output register.
// ----------------------------------------------------------------------------
module stereo_fuzz_distortion #(
    parameter int STATE_WIDTH = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       smp_valid,
    output logic                                       smp_ready,
    input  sfd_pkg::in_beat_t                          smp,
    output logic                                       res_valid,
    input  logic                                       res_ready,
    output sfd_pkg::out_beat_t                         res,
    input  logic                                       cfg_we,
    input  logic [sfd_pkg::REG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [sfd_pkg::CFG_DATA_WIDTH-1:0]         cfg_data
);

    localparam int CW = sfd_pkg::COEF_WIDTH;

    function automatic logic [CW-1:0] q16_unity(input logic [CW-1:0] v);
        return (v > sfd_pkg::Q16_ONE) ? sfd_pkg::Q16_ONE : v;
    endfunction

    sfd_pkg::cfg_t      cfg_reg, cfg_next;
    logic               res_valid_reg;
    sfd_pkg::out_beat_t res_reg;
    sfd_pkg::core_ctl_t core_ctl;
    sfd_pkg::core_sts_t core_sts;
    sfd_pkg::out_beat_t core_result;
    logic [CW-1:0]      cfg_unity;

    assign cfg_unity = q16_unity(cfg_data[CW-1:0]);

    always_comb
    begin
        cfg_next = cfg_reg;
        unique case (cfg_index)
            sfd_pkg::REG_DRIVE_GAIN:
                cfg_next.drive_gain = cfg_data[sfd_pkg::DRIVE_WIDTH-1:0];
            sfd_pkg::REG_TONE_MIX:
                cfg_next.tone_mix = cfg_unity;
            sfd_pkg::REG_CLEAN_BLEND:
                cfg_next.clean_blend = cfg_unity;
            sfd_pkg::REG_COEF_INPUT_HIGHPASS:
                cfg_next.coef_input_highpass = cfg_unity;
            sfd_pkg::REG_COEF_BASS_TAP:
                cfg_next.coef_bass_tap = cfg_unity;
            sfd_pkg::REG_COEF_INTERSTAGE:
                cfg_next.coef_interstage = cfg_unity;
            sfd_pkg::REG_COEF_TONE:
                cfg_next.coef_tone = cfg_unity;
            sfd_pkg::REG_COEF_DC_BLOCK:
                cfg_next.coef_dc_block = cfg_unity;
            default:
                cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= sfd_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign core_ctl.start    = smp_valid && core_sts.idle;
    assign core_ctl.out_free = !res_valid_reg || res_ready;

    sfd_core #(
        .STATE_WIDTH(STATE_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctl   (core_ctl),
        .smp   (smp),
        .sts   (core_sts),
        .result(core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (core_sts.done)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_sts.done)
        begin
            res_reg <= core_result;
        end
    end

    assign smp_ready = core_sts.idle;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/sfd_state_ram.sv =====
// ----------------------------------------------------------------------------
// Filter state memory
// One-port synchronous memory of per-channel filter states, registered
// read; entries never written read as zero.
// ----------------------------------------------------------------------------
module sfd_state_ram #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfd_pkg::ram_ctrl_t           ctrl,
    input  logic signed [DATA_WIDTH-1:0] wdata,
    output logic signed [DATA_WIDTH-1:0] rdata
);

    localparam int DEPTH = 1 << sfd_pkg::STATE_ADDR_WIDTH;

    logic signed [DATA_WIDTH-1:0] state_mem [DEPTH];
    logic [DEPTH-1:0]             valid_reg;
    logic signed [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            state_mem[ctrl.addr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= valid_reg[ctrl.addr] ? state_mem[ctrl.addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_reg[ctrl.addr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sfd_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed coefficient by signed working value, product registered.
// ----------------------------------------------------------------------------
module sfd_mul #(
    parameter int B_WIDTH = 35,
    localparam int P_WIDTH = B_WIDTH + sfd_pkg::MUL_A_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [sfd_pkg::MUL_A_WIDTH-1:0] a,
    input  logic signed [B_WIDTH-1:0]              b,
    output logic signed [P_WIDTH-1:0]              p
);

    logic signed [P_WIDTH-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= P_WIDTH'(a) * P_WIDTH'(b);
        end
    end

    assign p = p_reg;

endmodule

// ===== design/sfd_core.sv =====
// ----------------------------------------------------------------------------
// Fuzz sequencer and datapath
// Walks each channel through the pole filters and mixes, reading and
// writing filter states in the state memory over the shared multiplier.
// ----------------------------------------------------------------------------
module sfd_core #(
    parameter int STATE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sfd_pkg::cfg_t      cfg,
    input  sfd_pkg::core_ctl_t ctl,
    input  sfd_pkg::in_beat_t  smp,
    output sfd_pkg::core_sts_t sts,
    output sfd_pkg::out_beat_t result
);

    localparam int STATE_W = STATE_WIDTH;
    localparam int SMP_W   = sfd_pkg::SAMPLE_WIDTH;
    localparam int WORK_W  = ((STATE_W > SMP_W) ? STATE_W : SMP_W) + 3;
    localparam int MA_W    = sfd_pkg::MUL_A_WIDTH;
    localparam int PROD_W  = WORK_W + MA_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int IDX_W   = sfd_pkg::POLE_IDX_WIDTH;
    localparam int CW      = sfd_pkg::COEF_WIDTH;

    localparam logic signed [ACC_W-1:0] STATE_HI = ACC_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] STATE_LO = ~STATE_HI;
    localparam logic signed [ACC_W-1:0] SMP_HI   = ACC_W'((64'sd1 <<< (SMP_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SMP_LO   = ~SMP_HI;
    localparam logic signed [ACC_W-1:0] ONE_POS  = ACC_W'(64'sd1 <<< (SMP_W - 1));
    localparam logic signed [ACC_W-1:0] ONE_NEG  = -ONE_POS;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_BASS   = 4'd1;
    localparam logic [3:0] ST_HP     = 4'd2;
    localparam logic [3:0] ST_DRIVE  = 4'd3;
    localparam logic [3:0] ST_ONE    = 4'd4;
    localparam logic [3:0] ST_TWO    = 4'd5;
    localparam logic [3:0] ST_TLO    = 4'd6;
    localparam logic [3:0] ST_THI    = 4'd7;
    localparam logic [3:0] ST_LOGAIN = 4'd8;
    localparam logic [3:0] ST_LOMIX  = 4'd9;
    localparam logic [3:0] ST_HIMIX  = 4'd10;
    localparam logic [3:0] ST_DUCK   = 4'd11;
    localparam logic [3:0] ST_DRY    = 4'd12;
    localparam logic [3:0] ST_WET    = 4'd13;
    localparam logic [3:0] ST_DC     = 4'd14;
    localparam logic [3:0] ST_MAKEUP = 4'd15;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    localparam logic [IDX_W-1:0] IDX_INPUT_HP  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_BASS_TAP  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_STAGE_ONE = 3'd2;
    localparam logic [IDX_W-1:0] IDX_STAGE_TWO = 3'd3;
    localparam logic [IDX_W-1:0] IDX_TONE_LOW  = 3'd4;
    localparam logic [IDX_W-1:0] IDX_TONE_HIGH = 3'd5;
    localparam logic [IDX_W-1:0] IDX_DC_BLOCK  = 3'd6;

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > STATE_HI)
            r = STATE_HI[STATE_W-1:0];
        else if (v < STATE_LO)
            r = STATE_LO[STATE_W-1:0];
        else
            r = v[STATE_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > SMP_HI)
            r = SMP_HI[SMP_W-1:0];
        else if (v < SMP_LO)
            r = SMP_LO[SMP_W-1:0];
        else
            r = v[SMP_W-1:0];
        return r;
    endfunction

    function automatic logic signed [WORK_W-1:0] clip_one(input logic signed [ACC_W-1:0] v);
        logic signed [WORK_W-1:0] r;
        if (v > ONE_POS)
            r = ONE_POS[WORK_W-1:0];
        else if (v < ONE_NEG)
            r = ONE_NEG[WORK_W-1:0];
        else
            r = v[WORK_W-1:0];
        return r;
    endfunction

    logic [3:0]                step_reg, step_next;
    logic [1:0]                phase_reg, phase_next;
    logic                      chan_reg, chan_next;
    sfd_pkg::in_beat_t         smp_reg, smp_next;
    logic signed [WORK_W-1:0]  s_reg, s_next;
    logic signed [WORK_W-1:0]  lo_reg, lo_next;
    logic signed [WORK_W-1:0]  hi_reg, hi_next;
    logic signed [WORK_W-1:0]  m_reg, m_next;
    logic signed [WORK_W-1:0]  bass_reg, bass_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [CW-1:0]             duck_reg, duck_next;
    logic signed [STATE_W-1:0] z_reg, z_next;
    logic signed [SMP_W-1:0]   left_res_reg, left_res_next;

    logic signed [SMP_W-1:0]   x_smp;
    logic signed [WORK_W-1:0]  x_work;
    logic                      is_pole;
    logic [IDX_W-1:0]          pole_idx;
    logic signed [WORK_W-1:0]  pole_v;
    logic [CW-1:0]             pole_coef;
    logic signed [MA_W-1:0]    op_a;
    logic signed [WORK_W-1:0]  op_b;
    logic signed [STATE_W-1:0] pole_d;
    logic signed [STATE_W-1:0] z_new;
    logic signed [SMP_W-1:0]   lane_res;
    logic                      advance;
    logic                      done;

    sfd_pkg::ram_ctrl_t        ram_ctrl;
    logic signed [STATE_W-1:0] ram_rdata;
    logic                      mul_en;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [WORK_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    sfd_state_ram #(
        .DATA_WIDTH(STATE_W)
    ) u_state_ram (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (ram_ctrl),
        .wdata(z_new),
        .rdata(ram_rdata)
    );

    sfd_mul #(
        .B_WIDTH(WORK_W)
    ) u_mul (
        .clk(clk),
        .en (mul_en),
        .a  (mul_a),
        .b  (mul_b),
        .p  (mul_p)
    );

    assign x_smp    = chan_reg ? smp_reg.right_in : smp_reg.left_in;
    assign x_work   = WORK_W'(x_smp);
    assign pole_d   = sat_state(ACC_W'(pole_v) - ACC_W'(ram_rdata));
    assign z_new    = sat_state(ACC_W'(z_reg) + ACC_W'(mul_p >>> 16));
    assign lane_res = sat_smp(ACC_W'(mul_p >>> 16));

    // step table: pole address, input and coefficient, or multiply operands
    always_comb
    begin
        is_pole   = 1'b0;
        pole_idx  = IDX_INPUT_HP;
        pole_v    = s_reg;
        pole_coef = cfg.coef_interstage;
        op_a      = '0;
        op_b      = '0;
        unique case (step_reg)
            ST_BASS:
            begin
                is_pole   = 1'b1;
                pole_idx  = IDX_BASS_TAP;
                pole_v    = x_work;
                pole_coef = cfg.coef_bass_tap;
            end
            ST_HP:
            begin
                is_pole   = 1'b1;
                pole_idx  = IDX_INPUT_HP;
                pole_v    = x_work;
                pole_coef = cfg.coef_input_highpass;
            end
            ST_DRIVE:
            begin
                op_a = MA_W'(cfg.drive_gain);
                op_b = s_reg;
            end
            ST_ONE:
            begin
                is_pole   = 1'b1;
                pole_idx  = IDX_STAGE_ONE;
                pole_coef = cfg.coef_interstage;
            end
            ST_TWO:
            begin
                is_pole   = 1'b1;
                pole_idx  = IDX_STAGE_TWO;
                pole_coef = cfg.coef_interstage;
            end
            ST_TLO:
            begin
                is_pole   = 1'b1;
                pole_idx  = IDX_TONE_LOW;
                pole_coef = cfg.coef_tone;
            end
            ST_THI:
            begin
                is_pole   = 1'b1;
                pole_idx  = IDX_TONE_HIGH;
                pole_coef = cfg.coef_tone;
            end
            ST_LOGAIN:
            begin
                op_a = sfd_pkg::K_LOWPASS_GAIN;
                op_b = lo_reg;
            end
            ST_LOMIX:
            begin
                op_a = MA_W'(sfd_pkg::Q16_ONE) - MA_W'(cfg.tone_mix);
                op_b = lo_reg;
            end
            ST_HIMIX:
            begin
                op_a = MA_W'(cfg.tone_mix);
                op_b = hi_reg;
            end
            ST_DUCK:
            begin
                op_a = sfd_pkg::K_DUCK;
                op_b = WORK_W'(cfg.clean_blend);
            end
            ST_DRY:
            begin
                op_a = MA_W'(sfd_pkg::Q16_ONE) - MA_W'(duck_reg);
                op_b = m_reg;
            end
            ST_WET:
            begin
                op_a = MA_W'({cfg.clean_blend, 1'b0}) + MA_W'(cfg.clean_blend);
                op_b = bass_reg;
            end
            ST_DC:
            begin
                is_pole   = 1'b1;
                pole_idx  = IDX_DC_BLOCK;
                pole_v    = m_reg;
                pole_coef = cfg.coef_dc_block;
            end
            ST_MAKEUP:
            begin
                op_a = sfd_pkg::K_MAKEUP;
                op_b = s_reg;
            end
            default:
            begin
                is_pole = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        step_next     = step_reg;
        phase_next    = phase_reg;
        chan_next     = chan_reg;
        smp_next      = smp_reg;
        s_next        = s_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        m_next        = m_reg;
        bass_next     = bass_reg;
        acc_next      = acc_reg;
        duck_next     = duck_reg;
        z_next        = z_reg;
        left_res_next = left_res_reg;
        ram_ctrl      = '{rd_en: 1'b0, wr_en: 1'b0, addr: {chan_reg, pole_idx}};
        mul_en        = 1'b0;
        mul_a         = op_a;
        mul_b         = op_b;
        advance       = 1'b0;
        done          = 1'b0;

        if (step_reg == ST_IDLE)
        begin
            if (ctl.start)
            begin
                smp_next   = smp;
                chan_next  = 1'b0;
                step_next  = ST_BASS;
                phase_next = PH_A;
            end
        end
        else if (is_pole)
        begin
            unique case (phase_reg)
                PH_A:
                begin
                    ram_ctrl.rd_en = 1'b1;
                    phase_next     = PH_B;
                end
                PH_B:
                begin
                    z_next     = ram_rdata;
                    mul_en     = 1'b1;
                    mul_a      = MA_W'(pole_coef);
                    mul_b      = WORK_W'(pole_d);
                    phase_next = PH_C;
                end
                PH_C:
                begin
                    ram_ctrl.wr_en = 1'b1;
                    advance        = 1'b1;
                    phase_next     = PH_A;
                end
                default:
                begin
                    phase_next = PH_A;
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_A:
                begin
                    mul_en     = 1'b1;
                    phase_next = PH_B;
                end
                PH_B:
                begin
                    // hold the last step until the output register frees
                    if (step_reg != ST_MAKEUP || !chan_reg || ctl.out_free)
                    begin
                        advance    = 1'b1;
                        phase_next = PH_A;
                    end
                end
                default:
                begin
                    phase_next = PH_A;
                end
            endcase
        end

        if (advance)
        begin
            unique case (step_reg)
                ST_BASS:
                begin
                    bass_next = WORK_W'(z_new);
                    step_next = ST_HP;
                end
                ST_HP:
                begin
                    s_next    = x_work - WORK_W'(z_new);
                    step_next = ST_DRIVE;
                end
                ST_DRIVE:
                begin
                    s_next    = clip_one(ACC_W'(mul_p >>> 8));
                    step_next = ST_ONE;
                end
                ST_ONE:
                begin
                    s_next    = clip_one(ACC_W'(z_new) <<< 1);
                    step_next = ST_TWO;
                end
                ST_TWO:
                begin
                    s_next    = WORK_W'(z_new);
                    step_next = ST_TLO;
                end
                ST_TLO:
                begin
                    lo_next   = WORK_W'(z_new);
                    step_next = ST_THI;
                end
                ST_THI:
                begin
                    hi_next   = s_reg - WORK_W'(z_new);
                    step_next = ST_LOGAIN;
                end
                ST_LOGAIN:
                begin
                    lo_next   = WORK_W'(mul_p >>> 16);
                    step_next = ST_LOMIX;
                end
                ST_LOMIX:
                begin
                    acc_next  = ACC_W'(mul_p);
                    step_next = ST_HIMIX;
                end
                ST_HIMIX:
                begin
                    m_next    = WORK_W'((acc_reg + ACC_W'(mul_p)) >>> 16);
                    step_next = ST_DUCK;
                end
                ST_DUCK:
                begin
                    duck_next = CW'(mul_p >>> 16);
                    step_next = ST_DRY;
                end
                ST_DRY:
                begin
                    acc_next  = ACC_W'(mul_p);
                    step_next = ST_WET;
                end
                ST_WET:
                begin
                    m_next    = WORK_W'(sat_state((acc_reg + ACC_W'(mul_p)) >>> 16));
                    step_next = ST_DC;
                end
                ST_DC:
                begin
                    s_next    = m_reg - WORK_W'(z_new);
                    step_next = ST_MAKEUP;
                end
                ST_MAKEUP:
                begin
                    if (chan_reg)
                    begin
                        done      = 1'b1;
                        step_next = ST_IDLE;
                    end
                    else
                    begin
                        left_res_next = lane_res;
                        chan_next     = 1'b1;
                        step_next     = ST_BASS;
                    end
                end
                default:
                begin
                    step_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            phase_reg <= PH_A;
            chan_reg  <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            phase_reg <= phase_next;
            chan_reg  <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        s_reg        <= s_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        m_reg        <= m_next;
        bass_reg     <= bass_next;
        acc_reg      <= acc_next;
        duck_reg     <= duck_next;
        z_reg        <= z_next;
        left_res_reg <= left_res_next;
    end

    assign sts.idle         = (step_reg == ST_IDLE);
    assign sts.done         = done;
    assign result.left_out  = left_res_reg;
    assign result.right_out = lane_res;

endmodule

// ===== design/stereo_fuzz_distortion_checker.sv =====
// ----------------------------------------------------------------------------
// Stereo fuzz distortion port checker
// Watches the sample and result channels and the count of pairs in flight.
// ----------------------------------------------------------------------------
`include "stereo_fuzz_distortion_macros.svh"

module stereo_fuzz_distortion_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               smp_valid,
    input logic               smp_ready,
    input logic               res_valid,
    input logic               res_ready,
    input sfd_pkg::out_beat_t res
);

    logic [1:0] pending_reg, pending_next;
    logic       smp_fire;
    logic       res_fire;

    assign smp_fire = smp_valid && smp_ready;
    assign res_fire = res_valid && res_ready;

    always_comb
    begin
        unique case ({smp_fire, res_fire})
            2'b10:   pending_next = pending_reg + 2'd1;
            2'b01:   pending_next = pending_reg - 2'd1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `SFD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result beat changed while stalled")
    `SFD_ASSERT_NEXT(a_ready_drop, smp_fire, !smp_ready, "sample beat taken while a pair is in work")
    `SFD_ASSERT_SAME(a_res_source, res_valid, pending_reg != 2'd0, "result beat without a sample beat")
    `SFD_ASSERT_SAME(a_pending_bound, smp_valid || !smp_valid, pending_reg != 2'd3, "more than two pairs in flight")

endmodule

bind stereo_fuzz_distortion stereo_fuzz_distortion_checker u_checker (.*);

// ===== tb/stereo_fuzz_distortion_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo fuzz distortion testbench
// Drives sample pairs through the fuzz path under a series of control and
// coefficient settings (reset values, all zero, full scale, above unity,
// floor and random), predicts every processed pair in fixed point and checks
// each result beat in order. Sender and receiver idle at random, and the
// receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module stereo_fuzz_distortion_tb;

    import sfd_pkg::*;

    localparam int     STATE_BITS   = 32;
    localparam int     PHASES       = 24;
    localparam int     PHASE_PAIRS  = 80;
    localparam int     HOLD_CYCLES  = 500;
    localparam int     STALL_LIMIT  = 5000;
    localparam int     SETTLE       = 4;
    localparam int     TAIL_CYCLES  = 100;

    localparam longint ST_MAX     = (longint'(1) << (STATE_BITS - 1)) - 1;
    localparam longint ST_MIN     = -ST_MAX - 1;
    localparam longint FULL_SCALE = longint'(1) << (SAMPLE_WIDTH - 1);
    localparam longint SMP_MAX    = FULL_SCALE - 1;
    localparam longint SMP_MIN    = -FULL_SCALE;
    localparam longint UNITY      = 65536;
    localparam longint LP_GAIN    = 104858;
    localparam longint DUCK_GAIN  = 26214;
    localparam longint MAKEUP     = 15729;

    localparam logic [SAMPLE_WIDTH-1:0] P_MAX  = 24'h7FFFFF;
    localparam logic [SAMPLE_WIDTH-1:0] P_MIN  = 24'h800000;
    localparam logic [SAMPLE_WIDTH-1:0] P_ZERO = 24'h000000;
    localparam logic [SAMPLE_WIDTH-1:0] P_NEG1 = 24'hFFFFFF;
    localparam logic [SAMPLE_WIDTH-1:0] P_ONE  = 24'h000001;
    localparam logic [SAMPLE_WIDTH-1:0] P_5A   = 24'h555555;
    localparam logic [SAMPLE_WIDTH-1:0] P_A5   = 24'hAAAAAA;

    typedef enum int {
        POLE_INPUT_HP,
        POLE_BASS_TAP,
        POLE_STAGE_ONE,
        POLE_STAGE_TWO,
        POLE_TONE_LOW,
        POLE_TONE_HIGH,
        POLE_DC_BLOCK,
        POLE_COUNT
    } pole_e;

    typedef enum int {
        SET_ZERO,
        SET_TOP,
        SET_OVER,
        SET_FLOOR,
        SET_DEFAULT,
        SET_RANDOM
    } setting_e;

    typedef enum int {
        IDLE_SENDER_LIGHT,
        IDLE_RECEIVER_LIGHT,
        IDLE_NONE
    } idle_e;

    class fuzz_tracker;
        longint    drive;
        longint    tone_mix;
        longint    blend;
        longint    c_input_hp;
        longint    c_bass;
        longint    c_inter;
        longint    c_tone;
        longint    c_dc;
        longint    pole_z[2][POLE_COUNT];
        out_beat_t pending[$];
        int        errors;

        function new();
            drive      = longint'(CFG_RESET.drive_gain);
            tone_mix   = longint'(CFG_RESET.tone_mix);
            blend      = longint'(CFG_RESET.clean_blend);
            c_input_hp = longint'(CFG_RESET.coef_input_highpass);
            c_bass     = longint'(CFG_RESET.coef_bass_tap);
            c_inter    = longint'(CFG_RESET.coef_interstage);
            c_tone     = longint'(CFG_RESET.coef_tone);
            c_dc       = longint'(CFG_RESET.coef_dc_block);
            foreach (pole_z[c, p])
                pole_z[c][p] = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [REG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
            case (idx)
                REG_DRIVE_GAIN:          drive      = longint'(val[DRIVE_WIDTH-1:0]);
                REG_TONE_MIX:            tone_mix   = longint'(val);
                REG_CLEAN_BLEND:         blend      = longint'(val);
                REG_COEF_INPUT_HIGHPASS: c_input_hp = longint'(val);
                REG_COEF_BASS_TAP:       c_bass     = longint'(val);
                REG_COEF_INTERSTAGE:     c_inter    = longint'(val);
                REG_COEF_TONE:           c_tone     = longint'(val);
                REG_COEF_DC_BLOCK:       c_dc       = longint'(val);
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        endfunction

        function longint unity(longint c);
            return (c > UNITY) ? UNITY : c;
        endfunction

        function longint step_pole(int ch, pole_e p, longint coef, longint v);
            longint d;
            d = clamp(v - pole_z[ch][p], ST_MIN, ST_MAX);
            pole_z[ch][p] = clamp(pole_z[ch][p] + ((unity(coef) * d) >>> 16), ST_MIN, ST_MAX);
            return pole_z[ch][p];
        endfunction

        function longint fuzz_channel(int ch, longint x);
            longint tone, mix, bass, xin, s, lo, hi, m, duck, y;
            tone = unity(tone_mix);
            mix  = unity(blend);
            bass = step_pole(ch, POLE_BASS_TAP, c_bass, x);
            xin  = x - step_pole(ch, POLE_INPUT_HP, c_input_hp, x);
            s    = clamp((drive * xin) >>> 8, -FULL_SCALE, FULL_SCALE);
            s    = step_pole(ch, POLE_STAGE_ONE, c_inter, s);
            s    = clamp(2 * s, -FULL_SCALE, FULL_SCALE);
            s    = step_pole(ch, POLE_STAGE_TWO, c_inter, s);
            lo   = step_pole(ch, POLE_TONE_LOW, c_tone, s);
            hi   = s - step_pole(ch, POLE_TONE_HIGH, c_tone, s);
            m    = ((UNITY - tone) * ((lo * LP_GAIN) >>> 16) + tone * hi) >>> 16;
            duck = (mix * DUCK_GAIN) >>> 16;
            m    = clamp((m * (UNITY - duck) + 3 * mix * bass) >>> 16, ST_MIN, ST_MAX);
            y    = m - step_pole(ch, POLE_DC_BLOCK, c_dc, m);
            return clamp((y * MAKEUP) >>> 16, SMP_MIN, SMP_MAX);
        endfunction

        function void take_pair(in_beat_t b);
            out_beat_t e;
            e.left_out  = SAMPLE_WIDTH'(fuzz_channel(0, longint'(b.left_in)));
            e.right_out = SAMPLE_WIDTH'(fuzz_channel(1, longint'(b.right_in)));
            pending.push_back(e);
        endfunction

        function void match_pair(out_beat_t got);
            out_beat_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing pending: left %0d right %0d",
                         $time, got.left_out, got.right_out);
                return;
            end
            e = pending.pop_front();
            if (got.left_out !== e.left_out)
            begin
                errors++;
                $display("%0t: left_out expected %0d actual %0d",
                         $time, e.left_out, got.left_out);
            end
            if (got.right_out !== e.right_out)
            begin
                errors++;
                $display("%0t: right_out expected %0d actual %0d",
                         $time, e.right_out, got.right_out);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        smp_valid;
    logic                        smp_ready;
    in_beat_t                    smp;
    logic                        res_valid;
    logic                        res_ready;
    out_beat_t                   res;
    logic                        cfg_we;
    logic [REG_INDEX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data;

    fuzz_tracker tracker;
    int          snd_idle_pct;
    int          rcv_idle_pct;
    bit          hold_req;
    int          hold_left;
    int          stall_cycles;
    in_beat_t    last_pair;

    in_beat_t edge_pairs[20] = '{
        {P_MAX, P_MAX}, {P_MAX, P_MAX}, {P_MAX, P_MAX},
        {P_MIN, P_MIN}, {P_MIN, P_MIN}, {P_MIN, P_MIN},
        {P_ZERO, P_ZERO}, {P_ZERO, P_ZERO},
        {P_MAX, P_MIN}, {P_MIN, P_MAX},
        {P_NEG1, P_ONE}, {P_ONE, P_NEG1},
        {P_5A, P_A5}, {P_A5, P_5A},
        {P_MAX, P_MAX}, {P_MAX, P_MAX},
        {P_MIN, P_MIN}, {P_MIN, P_MIN},
        {P_ZERO, P_MAX}, {P_MIN, P_ZERO}
    };

    stereo_fuzz_distortion u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp       (smp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic logic [SAMPLE_WIDTH-1:0] edge_value();
        case ($urandom_range(4))
            0:       return P_MAX;
            1:       return P_MIN;
            2:       return P_ZERO;
            3:       return P_NEG1;
            default: return P_ONE;
        endcase
    endfunction

    function automatic in_beat_t next_pair();
        in_beat_t    b;
        logic [31:0] word;
        word = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                b.left_in  = word[SAMPLE_WIDTH-1:0];
                word       = $urandom;
                b.right_in = word[SAMPLE_WIDTH-1:0];
            end
            4:
            begin
                b.left_in  = edge_value();
                b.right_in = edge_value();
            end
            5, 6:
                b = last_pair;
            7:
            begin
                b.left_in  = {{11{word[12]}}, word[12:0]};
                b.right_in = {{11{word[28]}}, word[28:16]};
            end
            8:
            begin
                b.left_in  = -last_pair.left_in;
                b.right_in = -last_pair.right_in;
            end
            default:
            begin
                b.left_in  = word[SAMPLE_WIDTH-1:0];
                b.right_in = word[SAMPLE_WIDTH-1:0];
            end
        endcase
        last_pair = b;
        return b;
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] cfg_pick(setting_e s,
                                                           logic [REG_INDEX_WIDTH-1:0] idx);
        bit is_drive;
        int roll;
        is_drive = (idx == REG_DRIVE_GAIN);
        case (s)
            SET_ZERO:  return '0;
            SET_TOP:   return is_drive ? CFG_DATA_WIDTH'(12288) : CFG_DATA_WIDTH'(65536);
            SET_OVER:  return '1;
            SET_FLOOR: return is_drive ? CFG_DATA_WIDTH'(768) : CFG_DATA_WIDTH'(1);
            SET_DEFAULT:
                case (idx)
                    REG_DRIVE_GAIN:          return CFG_DATA_WIDTH'(CFG_RESET.drive_gain);
                    REG_TONE_MIX:            return CFG_RESET.tone_mix;
                    REG_CLEAN_BLEND:         return CFG_RESET.clean_blend;
                    REG_COEF_INPUT_HIGHPASS: return CFG_RESET.coef_input_highpass;
                    REG_COEF_BASS_TAP:       return CFG_RESET.coef_bass_tap;
                    REG_COEF_INTERSTAGE:     return CFG_RESET.coef_interstage;
                    REG_COEF_TONE:           return CFG_RESET.coef_tone;
                    default:                 return CFG_RESET.coef_dc_block;
                endcase
            default:
            begin
                roll = $urandom_range(15);
                if (roll < 2)
                    return is_drive ? CFG_DATA_WIDTH'(($urandom_range(1) != 0) ? 768 : 0) : '0;
                else if (roll < 4)
                    return is_drive ? CFG_DATA_WIDTH'(($urandom_range(1) != 0) ? 12288 : 16383)
                                    : CFG_DATA_WIDTH'(65536);
                else if (roll == 4)
                    return is_drive ? CFG_DATA_WIDTH'($urandom_range(16384, 131071))
                                    : CFG_DATA_WIDTH'($urandom_range(65537, 131071));
                else
                    return is_drive ? CFG_DATA_WIDTH'($urandom_range(768, 12288))
                                    : CFG_DATA_WIDTH'($urandom_range(65536));
            end
        endcase
    endfunction

    task automatic write_reg(logic [REG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        tracker.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic program_setting(setting_e s);
        write_reg(REG_DRIVE_GAIN,          cfg_pick(s, REG_DRIVE_GAIN));
        write_reg(REG_TONE_MIX,            cfg_pick(s, REG_TONE_MIX));
        write_reg(REG_CLEAN_BLEND,         cfg_pick(s, REG_CLEAN_BLEND));
        write_reg(REG_COEF_INPUT_HIGHPASS, cfg_pick(s, REG_COEF_INPUT_HIGHPASS));
        write_reg(REG_COEF_BASS_TAP,       cfg_pick(s, REG_COEF_BASS_TAP));
        write_reg(REG_COEF_INTERSTAGE,     cfg_pick(s, REG_COEF_INTERSTAGE));
        write_reg(REG_COEF_TONE,           cfg_pick(s, REG_COEF_TONE));
        write_reg(REG_COEF_DC_BLOCK,       cfg_pick(s, REG_COEF_DC_BLOCK));
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle(idle_e mode);
        case (mode)
            IDLE_SENDER_LIGHT:
            begin
                snd_idle_pct = 23;
                rcv_idle_pct = 50;
            end
            IDLE_RECEIVER_LIGHT:
            begin
                snd_idle_pct = 50;
                rcv_idle_pct = 23;
            end
            default:
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_pair(in_beat_t b);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            smp_valid <= 1'b0;
            @(negedge clk);
        end
        smp_valid <= 1'b1;
        smp       <= b;
        @(posedge clk);
        while (!smp_ready)
            @(posedge clk);
        tracker.take_pair(b);
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        smp_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // receiver side: random back-pressure, plus a long hold-off on request
    initial
    begin
        res_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            tracker.match_pair(res);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((smp_valid && smp_ready) || (res_valid && res_ready) || cfg_we)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("stereo_fuzz_distortion_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        setting_e kind;
        rst_n        = 1'b0;
        smp_valid    = 1'b0;
        smp          = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_req     = 1'b0;
        stall_cycles = 0;
        last_pair    = '0;
        tracker      = new();
        set_idle(IDLE_SENDER_LIGHT);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (edge_pairs[k])
            send_pair(edge_pairs[k]);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_pipe();
            kind = ((p % 8) < 5) ? setting_e'(p % 8) : SET_RANDOM;
            program_setting(kind);
            if (p < 8)
                set_idle(IDLE_SENDER_LIGHT);
            else if (p < 16)
                set_idle(IDLE_RECEIVER_LIGHT);
            else
                set_idle(IDLE_NONE);
            // back the block up while beats keep coming
            if (p == 16 || p == 21)
                hold_req = 1'b1;
            repeat (PHASE_PAIRS) send_pair(next_pair());
        end

        drain_pipe();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("stereo_fuzz_distortion_tb: done, clean");
        else
            $display("stereo_fuzz_distortion_tb: done, errors");
        $finish;
    end

endmodule
